/* sv/frame_load_monitor_assert.svh */
// Assertion macros for the frame load monitor.
// Included by files that check their own logic; no other dependencies.
`ifndef FRAME_LOAD_MONITOR_ASSERT_SVH
`define FRAME_LOAD_MONITOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FLM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame_load_monitor: same-cycle check failed");
`define FLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame_load_monitor: next-cycle check failed");
`else
`define FLM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define FLM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/flm_pkg.sv */
// Shared types and constants of the frame load monitor.
// No dependencies; imported by every module of the block.
package flm_pkg;

  localparam logic [1:0] REQ_BEGIN  = 2'd0;
  localparam logic [1:0] REQ_END    = 2'd1;
  localparam logic [1:0] REQ_REPORT = 2'd2;

  localparam logic [0:0] REG_LINES_PER_FRAME = 1'd0;
  localparam logic [0:0] REG_REPORT_EVERY    = 1'd1;

  localparam logic [9:0]  LpfReset    = 10'd313;
  localparam logic [15:0] ReportReset = 16'd50;
  localparam logic [6:0]  PctFull     = 7'd100;

  // divider: 32-bit dividend, 16-bit divisor, one quotient bit per cycle
  localparam int          DivW     = 32;
  localparam int          ProdW    = 17;
  localparam int          PctShift = DivW - ProdW;
  localparam logic [5:0]  AvgSteps = 6'(DivW);
  localparam logic [5:0]  PctSteps = 6'(ProdW);

  typedef struct packed {
    logic [1:0]  req_type;
    logic        ready_req;
    logic [15:0] vblank_count;
    logic [9:0]  scan_line;
  } item_t;

  typedef struct packed {
    logic [15:0] frame_count;
    logic [15:0] dropped;
    logic [9:0]  max_lines;
    logic [31:0] line_sum;
  } snap_t;

  typedef struct packed {
    logic [6:0]  max_load_percent;
    logic [6:0]  load_percent;
    logic [15:0] dropped_frames;
    logic [15:0] frame_count;
  } result_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [15:0]     divisor;
    logic [5:0]      steps;
  } div_req_t;

endpackage

/* sv/flm_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on flm_pkg for widths and the request struct.
module flm_div import flm_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  div_req_t        req,
  output logic            done,
  output logic [DivW-1:0] quotient
);

  logic [15:0]     rem;
  logic [DivW-1:0] quo;
  logic [15:0]     dvs;
  logic [5:0]      cnt;
  logic            run;
  logic [16:0]     shifted;
  logic [17:0]     diff;

  assign shifted  = {rem, quo[DivW-1]};
  assign diff     = {1'b0, shifted} - {2'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= req.steps;
      end else if (run) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (run) begin
      if (!diff[17]) begin
        rem <= diff[15:0];
        quo <= {quo[DivW-2:0], 1'b1};
      end else begin
        rem <= shifted[15:0];
        quo <= {quo[DivW-2:0], 1'b0};
      end
    end
  end

endmodule

/* sv/flm_track.sv */
// Event tracker: begin/end bookkeeping, dropped count, sums and report trigger.
// Depends on flm_pkg for request codes and the snapshot struct.
module flm_track import flm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  item_t       item,
  input  logic [9:0]  lines_per_frame,
  input  logic [15:0] report_period,
  output logic        go,
  output snap_t       snap
);

  logic        measuring, measuring_next;
  logic [15:0] last_vblank, last_vblank_next;
  logic [9:0]  start_line, start_line_next;
  logic [15:0] frames_seen, frames_seen_next;
  logic [15:0] dropped_total, dropped_total_next;
  logic [9:0]  max_lines, max_lines_next;
  logic [31:0] line_sum, line_sum_next;
  logic [15:0] passed;
  logic [10:0] wrapped;
  logic [9:0]  used;
  logic        want_report;

  assign passed  = item.vblank_count - last_vblank;
  assign wrapped = {1'b0, item.scan_line} + {1'b0, lines_per_frame} - {1'b0, start_line};
  assign used    = (item.scan_line >= start_line) ? (item.scan_line - start_line)
                                                  : wrapped[9:0];

  always_comb begin
    measuring_next     = measuring;
    last_vblank_next   = last_vblank;
    start_line_next    = start_line;
    frames_seen_next   = frames_seen;
    dropped_total_next = dropped_total;
    max_lines_next     = max_lines;
    line_sum_next      = line_sum;
    want_report        = 1'b0;
    go                 = 1'b0;
    case (item.req_type)
      REQ_BEGIN: begin
        if (!item.ready_req) begin
          measuring_next = 1'b0;
        end else begin
          if (measuring && passed > 16'd1) begin
            dropped_total_next = dropped_total + passed - 16'd1;
          end
          last_vblank_next = item.vblank_count;
          measuring_next   = 1'b1;
          start_line_next  = item.scan_line;
        end
      end
      REQ_END: begin
        if (measuring) begin
          line_sum_next    = line_sum + {22'b0, used};
          max_lines_next   = (used > max_lines) ? used : max_lines;
          frames_seen_next = frames_seen + 16'd1;
          want_report      = (frames_seen_next >= report_period);
        end
      end
      REQ_REPORT: begin
        want_report = 1'b1;
      end
      default: begin
      end
    endcase
    snap.frame_count = frames_seen_next;
    snap.dropped     = dropped_total_next;
    snap.max_lines   = max_lines_next;
    snap.line_sum    = line_sum_next;
    if (want_report && frames_seen_next != 16'd0) begin
      go                 = accept;
      frames_seen_next   = '0;
      dropped_total_next = '0;
      max_lines_next     = '0;
      line_sum_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      measuring     <= 1'b0;
      last_vblank   <= '0;
      start_line    <= '0;
      frames_seen   <= '0;
      dropped_total <= '0;
      max_lines     <= '0;
      line_sum      <= '0;
    end else if (accept) begin
      measuring     <= measuring_next;
      last_vblank   <= last_vblank_next;
      start_line    <= start_line_next;
      frames_seen   <= frames_seen_next;
      dropped_total <= dropped_total_next;
      max_lines     <= max_lines_next;
      line_sum      <= line_sum_next;
    end
  end

endmodule

/* sv/flm_report.sv */
// Report sequencer: average and load percentages through the shared divider,
// then the output register. Depends on flm_pkg; drives flm_div requests.
module flm_report import flm_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic [9:0]      lines_per_frame,
  input  logic            go,
  input  snap_t           snap,
  output logic            busy,
  output div_req_t        div_req,
  input  logic            div_done,
  input  logic [DivW-1:0] div_quo,
  output logic            out_valid,
  input  logic            out_ready,
  output result_t         result
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_AVG_GO    = 4'd1;
  localparam logic [3:0] S_AVG_WAIT  = 4'd2;
  localparam logic [3:0] S_PAVG_GO   = 4'd3;
  localparam logic [3:0] S_PAVG_WAIT = 4'd4;
  localparam logic [3:0] S_MAX_PREP  = 4'd5;
  localparam logic [3:0] S_PMAX_GO   = 4'd6;
  localparam logic [3:0] S_PMAX_WAIT = 4'd7;
  localparam logic [3:0] S_OUT       = 4'd8;

  logic [3:0]       state;
  snap_t            snap_r;
  logic [6:0]       avg_pct;
  logic [6:0]       max_pct;
  logic [ProdW-1:0] prod;
  logic [15:0]      avg_sat;
  logic [15:0]      lpf_ext;
  logic             avg_full;
  logic             max_full;
  logic             out_free;

  assign avg_sat  = (div_quo[DivW-1:16] != '0) ? 16'hFFFF : div_quo[15:0];
  assign lpf_ext  = {6'b0, lines_per_frame};
  assign avg_full = (lines_per_frame == 10'd0) || (avg_sat >= lpf_ext);
  assign max_full = (lines_per_frame == 10'd0) || (snap_r.max_lines >= lines_per_frame);
  assign out_free = !out_valid || out_ready;
  assign busy     = (state != S_IDLE);

  always_comb begin
    div_req.start    = (state == S_AVG_GO) || (state == S_PAVG_GO) || (state == S_PMAX_GO);
    div_req.dividend = {prod, {PctShift{1'b0}}};
    div_req.divisor  = lpf_ext;
    div_req.steps    = PctSteps;
    if (state == S_AVG_GO) begin
      div_req.dividend = snap_r.line_sum;
      div_req.divisor  = snap_r.frame_count;
      div_req.steps    = AvgSteps;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:      if (go) state <= S_AVG_GO;
        S_AVG_GO:    state <= S_AVG_WAIT;
        S_AVG_WAIT:  if (div_done) state <= avg_full ? S_MAX_PREP : S_PAVG_GO;
        S_PAVG_GO:   state <= S_PAVG_WAIT;
        S_PAVG_WAIT: if (div_done) state <= S_MAX_PREP;
        S_MAX_PREP:  state <= max_full ? S_OUT : S_PMAX_GO;
        S_PMAX_GO:   state <= S_PMAX_WAIT;
        S_PMAX_WAIT: if (div_done) state <= S_OUT;
        S_OUT:       if (out_free) state <= S_IDLE;
        default:     state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (go) snap_r <= snap;
      end
      S_AVG_WAIT: begin
        if (div_done) begin
          avg_pct <= PctFull;
          prod    <= ProdW'(avg_sat[9:0]) * ProdW'(PctFull);
        end
      end
      S_PAVG_WAIT: begin
        if (div_done) avg_pct <= div_quo[6:0];
      end
      S_MAX_PREP: begin
        max_pct <= PctFull;
        prod    <= ProdW'(snap_r.max_lines) * ProdW'(PctFull);
      end
      S_PMAX_WAIT: begin
        if (div_done) max_pct <= div_quo[6:0];
      end
      S_OUT: begin
        if (out_free) begin
          result.frame_count      <= snap_r.frame_count;
          result.dropped_frames   <= snap_r.dropped;
          result.load_percent     <= avg_pct;
          result.max_load_percent <= max_pct;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/frame_load_monitor.sv */
// Frame load monitor top level: config registers, stream ports, checks.
// Depends on flm_pkg, flm_track, flm_report, flm_div and the assert header.
//
// Begin, end and report-request items are taken one per cycle as long as no
// report is being computed. An item that produces a report (a report request
// with frames counted, or the end item that brings the frame count to the
// report period) holds off further input while the report is computed: the
// shared one-bit-per-cycle divider works out a 32-bit quotient for the
// average lines per frame and a 17-bit quotient for each of the two load
// percentages. A load that reads 100 skips its division. The report then
// sits in the output register; input is taken again while it waits to be
// read, and a following report holds off input until that register is free.
// Input tuser carries the request type; load values above 100 and a zero
// line count per frame read as 100.
`include "frame_load_monitor_assert.svh"
module frame_load_monitor import flm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // ready_req, vblank_count[15:0], scan_line[9:0]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // frame_count, dropped_frames, load_percent,
                                      // max_load_percent
);

  logic [9:0]      lines_per_frame;
  logic [15:0]     report_period;
  item_t           item;
  logic            accept;
  logic            go;
  snap_t           snap;
  logic            busy;
  div_req_t        div_req;
  logic            div_done;
  logic [DivW-1:0] div_quo;
  result_t         result;

  always_ff @(posedge clk) begin
    if (rst) begin
      lines_per_frame <= LpfReset;
      report_period   <= ReportReset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LINES_PER_FRAME: lines_per_frame <= cfg_data[9:0];
        REG_REPORT_EVERY:    report_period   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign item.req_type     = s_axis_tuser;
  assign item.ready_req    = s_axis_tdata[0];
  assign item.vblank_count = s_axis_tdata[16:1];
  assign item.scan_line    = s_axis_tdata[26:17];

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  flm_track u_track (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .item            (item),
    .lines_per_frame (lines_per_frame),
    .report_period   (report_period),
    .go              (go),
    .snap            (snap)
  );

  flm_report u_report (
    .clk             (clk),
    .rst             (rst),
    .lines_per_frame (lines_per_frame),
    .go              (go),
    .snap            (snap),
    .busy            (busy),
    .div_req         (div_req),
    .div_done        (div_done),
    .div_quo         (div_quo),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .result          (result)
  );

  flm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign m_axis_tdata = {2'b0, result.max_load_percent, result.load_percent,
                         result.dropped_frames, result.frame_count};

  `FLM_ASSERT_NEXT(a_report_blocks_input, clk, rst, accept && go, !s_axis_tready)
  `FLM_ASSERT_IMPL(a_load_bounded, clk, rst, m_axis_tvalid, m_axis_tdata[38:32] <= PctFull)
  `FLM_ASSERT_IMPL(a_max_bounded, clk, rst, m_axis_tvalid, m_axis_tdata[45:39] <= PctFull)
  `FLM_ASSERT_IMPL(a_frames_nonzero, clk, rst, m_axis_tvalid, m_axis_tdata[15:0] != 16'd0)

endmodule

/* tb/tb_frame_load_monitor.sv */
`timescale 1ns / 1ps
// Self-checking testbench for frame_load_monitor: drives begin, end and report
// items on the input stream, predicts each report and checks the output stream.
// Depends on flm_pkg and the frame_load_monitor RTL.
module tb_frame_load_monitor;
  import flm_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT = 1000000;

  class frame_report_model;
    logic [9:0]  lines_per_frame;
    logic [15:0] report_period;
    logic        measuring;
    logic [15:0] last_vblank;
    logic [9:0]  start_line;
    logic [15:0] frames_seen;
    logic [15:0] dropped_total;
    logic [9:0]  max_lines;
    logic [31:0] line_sum;
    result_t     pending_reports[$];
    int          errors;

    function new();
      lines_per_frame = LpfReset;
      report_period = ReportReset;
      measuring = 1'b0;
      last_vblank = '0;
      start_line = '0;
      frames_seen = '0;
      dropped_total = '0;
      max_lines = '0;
      line_sum = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [15:0] val);
      if (idx == REG_LINES_PER_FRAME) begin
        lines_per_frame = val[9:0];
      end else begin
        report_period = val;
      end
    endfunction

    function logic [6:0] load_of(logic [31:0] lines);
      logic [31:0] pct;
      if (lines_per_frame == '0) return PctFull;
      pct = (lines * 32'd100) / {22'd0, lines_per_frame};
      return (pct > 32'd100) ? PctFull : pct[6:0];
    endfunction

    function void close_period();
      logic [31:0] avg;
      result_t r;
      if (frames_seen == '0) return;
      avg = line_sum / {16'd0, frames_seen};
      if (avg > 32'hFFFF) avg = 32'hFFFF;
      r.frame_count = frames_seen;
      r.dropped_frames = dropped_total;
      r.load_percent = load_of(avg);
      r.max_load_percent = load_of({22'd0, max_lines});
      pending_reports.push_back(r);
      frames_seen = '0;
      dropped_total = '0;
      max_lines = '0;
      line_sum = '0;
    endfunction

    function void note_item(item_t it);
      logic [15:0] passed;
      logic [9:0]  used;
      case (it.req_type)
        REQ_BEGIN: begin
          if (!it.ready_req) begin
            measuring = 1'b0;
          end else begin
            if (measuring) begin
              passed = it.vblank_count - last_vblank;
              if (passed > 16'd1) dropped_total = dropped_total + passed - 16'd1;
            end
            last_vblank = it.vblank_count;
            measuring = 1'b1;
            start_line = it.scan_line;
          end
        end
        REQ_END: begin
          if (measuring) begin
            if (it.scan_line >= start_line) begin
              used = it.scan_line - start_line;
            end else begin
              used = it.scan_line + lines_per_frame - start_line;  // mod 1024
            end
            line_sum = line_sum + {22'd0, used};
            if (used > max_lines) max_lines = used;
            frames_seen = frames_seen + 16'd1;
            if (frames_seen >= report_period) close_period();
          end
        end
        REQ_REPORT: begin
          close_period();
        end
        default: begin
        end
      endcase
    endfunction

    task flag(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_report(logic [47:0] data);
      result_t got;
      result_t want;
      got = data[45:0];
      if (pending_reports.size() == 0) begin
        flag($sformatf("unexpected report: frames %0d dropped %0d load %0d max %0d",
                       got.frame_count, got.dropped_frames, got.load_percent,
                       got.max_load_percent));
        return;
      end
      want = pending_reports.pop_front();
      if (got !== want) begin
        flag($sformatf("report: got %0d/%0d/%0d/%0d, want %0d/%0d/%0d/%0d",
                       got.frame_count, got.dropped_frames, got.load_percent,
                       got.max_load_percent, want.frame_count, want.dropped_frames,
                       want.load_percent, want.max_load_percent));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // ready_req, vblank_count[15:0], scan_line[9:0]
  logic [1:0]  s_axis_tuser = '0;   // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // frame_count, dropped_frames, load_percent,
                                    // max_load_percent

  frame_report_model model = new();
  int          cycles = 0;
  int          sink_stall = 0;
  int          sink_draw;
  bit          sink_steady = 1'b0;
  bit          src_steady = 1'b0;
  logic [15:0] vbl_clock = '0;

  frame_load_monitor dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // report sink with random stalls
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_stall <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      model.check_report(m_axis_tdata);
      if ($urandom_range(0, 31) == 0) sink_steady = !sink_steady;
      sink_draw = sink_steady ? 0 : $urandom_range(0, 19);
      sink_stall <= (sink_draw > 0) ? sink_draw - 1 : 0;
      m_axis_tready <= (sink_draw == 0);
    end else if (!m_axis_tready) begin
      if (sink_stall == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        sink_stall <= sink_stall - 1;
      end
    end
  end

  function automatic item_t mk_item(logic [1:0] kind, logic ready, logic [15:0] vbl,
                                    logic [9:0] line);
    item_t it;
    it.req_type = kind;
    it.ready_req = ready;
    it.vblank_count = vbl;
    it.scan_line = line;
    return it;
  endfunction

  function automatic logic [9:0] pick_line();
    if ($urandom_range(0, 9) == 0) return 10'($urandom_range(0, 1022));
    return 10'($urandom_range(0, model.lines_per_frame - 1));
  endfunction

  function automatic item_t noise_item(logic [1:0] kind);
    return mk_item(kind, 1'($urandom), 16'($urandom), 10'($urandom_range(0, 1022)));
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    if ($urandom_range(0, 31) == 0) src_steady = !src_steady;
    gap = src_steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, it.scan_line, it.vblank_count, it.ready_req};
    s_axis_tuser <= it.req_type;
    do @(posedge clk); while (!s_axis_tready);
    model.note_item(it);
  endtask

  // let all reports drain and the divider go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (model.pending_reports.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] lpf, logic [15:0] every);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_LINES_PER_FRAME;
    cfg_data <= lpf;
    @(posedge clk);
    cfg_index <= REG_REPORT_EVERY;
    cfg_data <= every;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model.set_reg(REG_LINES_PER_FRAME, lpf);
    model.set_reg(REG_REPORT_EVERY, every);
  endtask

  // mostly begin/end frame pairs with plausible vblank steps, plus noise
  task automatic run_traffic(int count);
    int sent;
    int pick;
    int step;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        step = $urandom_range(0, 99);
        if (step < 60) vbl_clock = vbl_clock + 16'd1;
        else if (step < 92 && step >= 75) vbl_clock = vbl_clock + 16'($urandom_range(2, 5));
        else if (step >= 92) vbl_clock = 16'($urandom);
        send_item(mk_item(REQ_BEGIN, 1'b1, vbl_clock, pick_line()));
        send_item(mk_item(REQ_END, 1'($urandom), 16'($urandom), pick_line()));
        sent += 2;
      end else begin
        if (pick < 80) send_item(noise_item(REQ_REPORT));
        else if (pick < 86) send_item(mk_item(REQ_BEGIN, 1'b0, 16'($urandom),
                                               10'($urandom_range(0, 1022))));
        else if (pick < 90) send_item(noise_item(REQ_UNUSED));
        else if (pick < 95) send_item(noise_item(REQ_END));
        else send_item(mk_item(REQ_BEGIN, 1'b1, 16'($urandom), pick_line()));
        sent += 1;
      end
    end
    settle();
  endtask

  initial begin
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset settings (313 lines, report every 50)
    send_item(mk_item(REQ_REPORT, 1'b0, 16'h0000, 10'd0));      // nothing counted
    send_item(mk_item(REQ_END, 1'b1, 16'hFFFF, 10'd5));         // not measuring
    send_item(mk_item(REQ_UNUSED, 1'b1, 16'hFFFF, 10'd1022));
    send_item(mk_item(REQ_BEGIN, 1'b0, 16'hFFFF, 10'd1022));
    send_item(mk_item(REQ_BEGIN, 1'b1, 16'h0000, 10'd0));
    send_item(mk_item(REQ_END, 1'b0, 16'h0000, 10'd1022));      // load saturates
    send_item(mk_item(REQ_REPORT, 1'b1, 16'hFFFF, 10'd1022));
    send_item(mk_item(REQ_BEGIN, 1'b1, 16'hFFFF, 10'd312));     // big vblank jump
    send_item(mk_item(REQ_END, 1'b1, 16'h0000, 10'd0));         // line wraps
    send_item(mk_item(REQ_BEGIN, 1'b1, 16'h0000, 10'd100));     // vblank wraps by one
    send_item(mk_item(REQ_END, 1'b1, 16'h0000, 10'd100));
    send_item(mk_item(REQ_BEGIN, 1'b1, 16'h0000, 10'd5));
    send_item(mk_item(REQ_END, 1'b1, 16'h0000, 10'd317));
    send_item(mk_item(REQ_BEGIN, 1'b0, 16'h1234, 10'd7));       // stop measuring
    send_item(mk_item(REQ_END, 1'b1, 16'h0000, 10'd200));
    send_item(mk_item(REQ_REPORT, 1'b0, 16'h0000, 10'd0));
    send_item(mk_item(REQ_REPORT, 1'b0, 16'h0000, 10'd0));
    send_item(mk_item(REQ_BEGIN, 1'b1, 16'd10, 10'd1022));
    send_item(mk_item(REQ_END, 1'b1, 16'd0, 10'd0));            // mod 1024 line count
    send_item(mk_item(REQ_BEGIN, 1'b1, 16'd12, 10'd200));
    send_item(mk_item(REQ_END, 1'b1, 16'd0, 10'd199));
    send_item(mk_item(REQ_REPORT, 1'b1, 16'hFFFF, 10'd1022));
    settle();

    set_config(16'd1023, 16'd1);
    run_traffic(240);
    set_config(16'd1, 16'd65535);
    run_traffic(240);
    set_config(16'($urandom_range(2, 1022)), 16'($urandom_range(1, 6)));
    run_traffic(240);
    set_config(16'd313, 16'd50);
    run_traffic(240);
    set_config(16'($urandom_range(1, 1023)), 16'($urandom_range(1, 3)));
    run_traffic(240);
    set_config(16'($urandom_range(200, 1023)), 16'($urandom_range(1, 20)));
    run_traffic(240);

    if (model.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
